@@ design/motion_command_safety_supervisor_macros.svh @@
// assertion macros for the motion command safety supervisor
// used by the top level only; expects a signal named clock and one named reset in scope
`ifndef MOTION_COMMAND_SAFETY_SUPERVISOR_MACROS_SVH
`define MOTION_COMMAND_SAFETY_SUPERVISOR_MACROS_SVH

// checked on every edge outside reset
`define MCSS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define MCSS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/mcss_pkg.sv @@
// types and constants of the motion command safety supervisor
// no dependencies
`timescale 1ns / 1ps

package mcss_pkg;

   localparam int unsigned ADDR_WIDTH = 5;
   localparam int unsigned DATA_WIDTH = 32;

   localparam logic [31:0] MAX_DISTANCE_RESET      = 32'd65536;
   localparam logic [31:0] MAX_TURN_RESET          = 32'd23592960;
   localparam logic [31:0] LEASE_TIMEOUT_RESET     = 32'd1000;
   localparam logic [15:0] OBSTACLE_LIMIT_RESET    = 16'd200;
   localparam logic [31:0] LOSS_TIMEOUT_RESET      = 32'd500;

   typedef enum logic [2:0] {
      REG_MAX_DISTANCE   = 3'd0,
      REG_MAX_TURN       = 3'd1,
      REG_LEASE_TIMEOUT  = 3'd2,
      REG_OBSTACLE_LIMIT = 3'd3,
      REG_LOSS_TIMEOUT   = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_FWD     = 3'd1,
      OP_BACK    = 3'd2,
      OP_LEFT    = 3'd3,
      OP_RIGHT   = 3'd4,
      OP_STOP    = 3'd5,
      OP_REFRESH = 3'd6,
      OP_BEGIN   = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_CENTER = 2'd1,
      MODE_FWD    = 2'd2,
      MODE_OTHER  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_STOP  = 3'd1,
      CMD_FWD   = 3'd2,
      CMD_BACK  = 3'd3,
      CMD_LEFT  = 3'd4,
      CMD_RIGHT = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] now_ms;
      logic [31:0] amount;
      logic        motor_busy;
      logic        scan_done;
      logic        scan_ok;
      logic [15:0] scan_mm;
      logic        range_ok;
      logic [15:0] range_mm;
   } req_item_type;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  motor_cmd;
      logic [31:0] motor_amount;
      logic        look_center;
      logic [1:0]  mode_now;
      logic        busy_res;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] max_distance;
      logic [31:0] max_turn;
      logic [31:0] lease_timeout_ms;
      logic [15:0] obstacle_limit_mm;
      logic [31:0] loss_timeout_ms;
   } cfg_type;

endpackage

@@ design/mcss_regs.sv @@
// configuration register bank with a two-phase register port
// depends on mcss_pkg
`timescale 1ns / 1ps

module mcss_regs
   import mcss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_WIDTH-1:0] paddr,
   input  logic [DATA_WIDTH-1:0] pwdata,
   output logic [DATA_WIDTH-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = reg_index_type'(paddr[ADDR_WIDTH-1:2]);
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en && (paddr[1:0] == 2'b00)) begin
         case (idx)
            REG_MAX_DISTANCE:   cfg_in.max_distance      = pwdata;
            REG_MAX_TURN:       cfg_in.max_turn          = pwdata;
            REG_LEASE_TIMEOUT:  cfg_in.lease_timeout_ms  = pwdata;
            REG_OBSTACLE_LIMIT: cfg_in.obstacle_limit_mm = pwdata[15:0];
            REG_LOSS_TIMEOUT:   cfg_in.loss_timeout_ms   = pwdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_MAX_DISTANCE:   prdata = cfg_ff.max_distance;
         REG_MAX_TURN:       prdata = cfg_ff.max_turn;
         REG_LEASE_TIMEOUT:  prdata = cfg_ff.lease_timeout_ms;
         REG_OBSTACLE_LIMIT: prdata = {16'd0, cfg_ff.obstacle_limit_mm};
         REG_LOSS_TIMEOUT:   prdata = cfg_ff.loss_timeout_ms;
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_distance      <= MAX_DISTANCE_RESET;
         cfg_ff.max_turn          <= MAX_TURN_RESET;
         cfg_ff.lease_timeout_ms  <= LEASE_TIMEOUT_RESET;
         cfg_ff.obstacle_limit_mm <= OBSTACLE_LIMIT_RESET;
         cfg_ff.loss_timeout_ms   <= LOSS_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/mcss_ctrl.sv @@
// supervisor state machine: mode, lease, lost-reading tracking and result decode
// depends on mcss_pkg
`timescale 1ns / 1ps

module mcss_ctrl
   import mcss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   mode_type    mode_ff, mode_in;
   logic [31:0] pending_ff, pending_in;
   logic        lost_ff, lost_in;
   logic [31:0] lost_since_ff, lost_since_in;
   logic [31:0] lease_start_ff, lease_start_in;

   opcode_type  op;
   logic        lease_exp;
   logic        loss_exp;
   logic        scan_near;
   logic        range_near;
   logic        is_submit;
   logic        is_turn;
   logic [31:0] limit;
   logic        sub_ok;
   logic        center_halt;
   logic        fwd_halt;
   logic        tick_halt;
   logic        go_fwd;

   assign op         = opcode_type'(item.opcode);
   assign lease_exp  = (item.now_ms - lease_start_ff) >= cfg.lease_timeout_ms;
   assign loss_exp   = (item.now_ms - lost_since_ff) >= cfg.loss_timeout_ms;
   assign scan_near  = item.scan_mm < cfg.obstacle_limit_mm;
   assign range_near = item.range_mm < cfg.obstacle_limit_mm;
   assign is_submit  = (op == OP_FWD) || (op == OP_BACK) || (op == OP_LEFT) || (op == OP_RIGHT);
   assign is_turn    = (op == OP_LEFT) || (op == OP_RIGHT);
   assign limit      = is_turn ? cfg.max_turn : cfg.max_distance;
   assign sub_ok     = is_submit && (mode_ff == MODE_IDLE) && !item.motor_busy
                       && (item.amount != 32'd0) && (item.amount <= limit);

   assign center_halt = (mode_ff == MODE_CENTER) && item.scan_done
                        && (!item.scan_ok || scan_near);
   assign fwd_halt    = (mode_ff == MODE_FWD)
                        && ((item.range_ok && range_near) || (!item.range_ok && lost_ff && loss_exp));
   assign tick_halt   = lease_exp || center_halt || fwd_halt;
   assign go_fwd      = !lease_exp && (mode_ff == MODE_CENTER) && item.scan_done
                        && item.scan_ok && !scan_near;

   // next state
   always_comb begin
      mode_in        = mode_ff;
      pending_in     = pending_ff;
      lost_in        = lost_ff;
      lost_since_in  = lost_since_ff;
      lease_start_in = lease_start_ff;
      case (op)
         OP_TICK: begin
            if (tick_halt) begin
               mode_in = MODE_IDLE;
               lost_in = 1'b0;
            end else if (go_fwd) begin
               mode_in = MODE_FWD;
               lost_in = 1'b0;
            end else if (mode_ff == MODE_FWD) begin
               if (item.range_ok) begin
                  lost_in = 1'b0;
               end else if (!lost_ff) begin
                  lost_in       = 1'b1;
                  lost_since_in = item.now_ms;
               end
               if (!item.motor_busy) begin
                  mode_in = MODE_IDLE;
               end
            end else if ((mode_ff == MODE_OTHER) && !item.motor_busy) begin
               mode_in = MODE_IDLE;
            end
         end
         OP_FWD: begin
            if (sub_ok) begin
               mode_in    = MODE_CENTER;
               pending_in = item.amount;
               lost_in    = 1'b0;
            end
         end
         OP_BACK, OP_LEFT, OP_RIGHT: begin
            if (sub_ok) begin
               mode_in = MODE_OTHER;
            end
         end
         OP_STOP: begin
            mode_in = MODE_IDLE;
            lost_in = 1'b0;
         end
         OP_REFRESH: begin
            lease_start_in = item.now_ms;
         end
         OP_BEGIN: begin
            mode_in        = MODE_IDLE;
            lease_start_in = item.now_ms;
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   // result
   always_comb begin
      result              = '0;
      result.accepted     = sub_ok;
      result.motor_cmd    = CMD_NONE;
      result.motor_amount = 32'd0;
      case (op)
         OP_TICK: begin
            if (tick_halt) begin
               result.motor_cmd = CMD_STOP;
            end else if (go_fwd) begin
               result.motor_cmd    = CMD_FWD;
               result.motor_amount = pending_ff;
            end
         end
         OP_FWD: begin
            result.look_center = sub_ok;
         end
         OP_BACK: begin
            if (sub_ok) begin
               result.motor_cmd    = CMD_BACK;
               result.motor_amount = item.amount;
            end
         end
         OP_LEFT: begin
            if (sub_ok) begin
               result.motor_cmd    = CMD_LEFT;
               result.motor_amount = item.amount;
            end
         end
         OP_RIGHT: begin
            if (sub_ok) begin
               result.motor_cmd    = CMD_RIGHT;
               result.motor_amount = item.amount;
            end
         end
         OP_STOP: begin
            result.motor_cmd = CMD_STOP;
         end
         OP_REFRESH: begin
            result.motor_cmd = CMD_NONE;
         end
         OP_BEGIN: begin
            result.motor_cmd   = CMD_STOP;
            result.look_center = 1'b1;
         end
         default: begin
            result.motor_cmd = CMD_NONE;
         end
      endcase
      result.mode_now = mode_in;
      result.busy_res = (mode_in != MODE_IDLE) || item.motor_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         pending_ff     <= '0;
         lost_ff        <= 1'b0;
         lost_since_ff  <= '0;
         lease_start_ff <= '0;
      end else if (step) begin
         mode_ff        <= mode_in;
         pending_ff     <= pending_in;
         lost_ff        <= lost_in;
         lost_since_ff  <= lost_since_in;
         lease_start_ff <= lease_start_in;
      end
   end

endmodule

@@ design/motion_command_safety_supervisor.sv @@
// channel     | direction | handshake          | payload
// req         | in        | req_valid/stall    | req_item_type
// rsp         | out       | rsp_valid/stall    | rsp_item_type
// csr         | in/out    | psel/penable/pwrite| 32-bit register data
// one transaction per cycle sustained while rsp is not stalled; the accepting edge
// loads the input register; the result register, which drives rsp_valid, is loaded
// as the transaction leaves the input register, and the supervisor state updates with it
// synchronous reset returns the valid flags, state and configuration to reset values
// a stalled result holds the input register, which then stalls req
// top level; depends on mcss_pkg, mcss_regs, mcss_ctrl and the macros header
`timescale 1ns / 1ps

`include "motion_command_safety_supervisor_macros.svh"

module motion_command_safety_supervisor
   import mcss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_WIDTH-1:0] paddr,
   input  logic [DATA_WIDTH-1:0] pwdata,
   output logic [DATA_WIDTH-1:0] prdata,
   output logic                  pready
);

   cfg_type      cfg;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type result;
   logic         advance;
   logic         req_take;
   logic         stop_step;
   logic         lease_stop_step;
   logic         stop_out;

   mcss_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mcss_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_stall) begin
         out_valid_in = out_valid_ff;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign stop_step       = advance && (in_item_ff.opcode == OP_STOP);
   assign lease_stop_step = advance && (in_item_ff.opcode == OP_TICK)
                            && (cfg.lease_timeout_ms == 32'd0);
   assign stop_out        = rsp_valid && (rsp_payload.mode_now == MODE_IDLE)
                            && (rsp_payload.motor_cmd == CMD_STOP);

   `MCSS_ASSERT(a_take_loads, req_valid && !req_stall |=> in_valid_ff, "accepted transaction lost")
   `MCSS_ASSERT(a_stop_idles, stop_step |=> stop_out, "stop did not halt")
   `MCSS_ASSERT(a_zero_lease, lease_stop_step |=> stop_out, "expired lease did not stop")
   `MCSS_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid && !req_stall, "pipeline not empty")

endmodule
